>>> hw/rtl/plof_pkg.sv
// ----------------------------------------------------------------------------
// plof_pkg
// Shared types and codes for the price level order queue.
// ----------------------------------------------------------------------------
`default_nettype none

package plof_pkg;

    localparam int KEY_W = 32;
    localparam int VOL_W = 37;
    localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_ERASE   = 2'd1;
    localparam logic [1:0] CMD_FULFILL = 2'd2;

    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_DUP     = 3'd1;
    localparam logic [2:0] STS_BAD     = 3'd2;
    localparam logic [2:0] STS_FULL    = 3'd3;
    localparam logic [2:0] STS_MISSING = 3'd4;

    localparam logic [1:0] REG_SIDE  = 2'd0;
    localparam logic [1:0] REG_PRICE = 2'd1;

    localparam logic KIND_CLOSE = 1'b0;
    localparam logic KIND_TRADE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              key_hit;
        logic [KEY_W-1:0]  avail;
        logic [KEY_W-1:0]  fill;
        logic [KEY_W-1:0]  filled_new;
        logic              full;
    } match_t;

endpackage

`default_nettype wire

>>> hw/rtl/price_level_order_fifo.sv
// ----------------------------------------------------------------------------
// price_level_order_fifo
// One price level of an order book: FIFO of resting orders with insert,
// erase by id and first-in first-out matching of incoming orders.
// ----------------------------------------------------------------------------
// Busy rises at the accepting edge and holds through the scan, shift or match walk
// over the resting orders that the command needs, and through the completion state.
// The closing result strobes in the same cycle as busy falls.
// Throughput: one transaction at a time; the slot memory is visited one
// entry per cycle through its single read port. Results cannot be stalled.
// Reset clears the queue count, volume and configuration; no clearing pass.
`default_nettype none

module price_level_order_fifo
    import plof_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] order_key,
    input  wire logic        order_side,
    input  wire logic [31:0] order_price,
    input  wire logic [31:0] order_size,
    input  wire logic [31:0] order_done,
    output logic             strobe,
    output logic             item_kind,
    output logic [2:0]       status,
    output logic [31:0]      resting_key,
    output logic [31:0]      traded_volume,
    output logic             resting_complete,
    output logic [31:0]      request_filled,
    output logic             request_complete,
    output logic [36:0]      open_volume,
    output logic [5:0]       order_count,
    output logic             last
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    state_t state_reg, state_next;

    logic             side_cfg_reg;
    logic [31:0]      price_cfg_reg;

    logic [1:0]       cmd_reg, cmd_next;
    logic [31:0]      key_reg, key_next;
    logic             side_reg, side_next;
    logic [31:0]      price_reg, price_next;
    logic [31:0]      size_reg, size_next;
    logic [31:0]      done_reg, done_next;
    logic [2:0]       sts_reg, sts_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [VOL_W-1:0] vol_reg, vol_next;
    logic [CW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    pidx_reg, pidx_next;
    logic             pv_reg, pv_next;
    logic [CW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]    n_reg, n_next;
    logic             stop_reg, stop_next;

    logic             strobe_reg;
    logic             kind_reg;
    logic [2:0]       ost_reg;
    logic [31:0]      rkey_out_reg;
    logic [31:0]      tvol_reg;
    logic             rcomp_reg;
    logic [31:0]      rfill_out_reg;
    logic             rcompl_reg;
    logic [VOL_W-1:0] ovol_reg;
    logic [CW-1:0]    ocnt_reg;
    logic             last_reg;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [31:0]      mem_wkey, mem_wsize, mem_wfill;
    logic [31:0]      mem_rkey, mem_rsize, mem_rfill;

    logic             active;
    logic [CW-1:0]    limit;
    logic             issue;
    logic             scan_hit;
    logic             scan_end;
    logic             seq_end;
    logic             ins_bad;
    logic             ful_bad;
    logic [VOL_W:0]   vol_sum;
    logic             emit_trade;
    logic             emit_close;
    logic [31:0]      req_avail;

    match_t           alu_res;

    plof_store #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wkey  (mem_wkey),
        .wsize (mem_wsize),
        .wfill (mem_wfill),
        .raddr (rd_ptr_reg[AW-1:0]),
        .rkey  (mem_rkey),
        .rsize (mem_rsize),
        .rfill (mem_rfill)
    );

    assign req_avail = stop_reg ? '0 : (size_reg - done_reg);

    plof_alu u_alu (
        .rest_key  (mem_rkey),
        .rest_size (mem_rsize),
        .rest_fill (mem_rfill),
        .req_key   (key_reg),
        .req_avail (req_avail),
        .res       (alu_res)
    );

    assign active   = (state_reg == ST_SCAN) || (state_reg == ST_SHIFT)
                   || (state_reg == ST_WALK);
    assign limit    = (state_reg == ST_WALK) ? n_reg : count_reg;
    assign scan_hit = (state_reg == ST_SCAN) && pv_reg && alu_res.key_hit;
    assign issue    = active && (rd_ptr_reg < limit) && !scan_hit;
    assign scan_end = (state_reg == ST_SCAN) && (scan_hit || (!issue && !pv_reg));
    assign seq_end  = !issue && !pv_reg;
    assign ins_bad  = (side_reg != side_cfg_reg) || (price_reg != price_cfg_reg)
                   || (size_reg == '0) || (done_reg > size_reg);
    assign ful_bad  = (order_side == side_cfg_reg) || (order_price != price_cfg_reg)
                   || (order_size == '0) || (order_done > order_size);
    assign vol_sum  = {1'b0, vol_reg} + (VOL_W + 1)'(size_reg - done_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (command == CMD_INSERT || command == CMD_ERASE)
                        state_next = ST_SCAN;
                    else if (command == CMD_FULFILL && count_reg != '0 && !ful_bad)
                        state_next = ST_WALK;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                    state_next = (cmd_reg == CMD_ERASE && scan_hit) ? ST_SHIFT : ST_DONE;
            end
            ST_SHIFT:
            begin
                if (seq_end)
                    state_next = ST_DONE;
            end
            ST_WALK:
            begin
                if (seq_end)
                    state_next = ST_DONE;
            end
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        side_next   = side_reg;
        price_next  = price_reg;
        size_next   = size_reg;
        done_next   = done_reg;
        sts_next    = sts_reg;
        count_next  = count_reg;
        vol_next    = vol_reg;
        rd_ptr_next = issue ? (rd_ptr_reg + CW'(1)) : rd_ptr_reg;
        pidx_next   = rd_ptr_reg;
        pv_next     = issue;
        wr_ptr_next = wr_ptr_reg;
        n_next      = n_reg;
        stop_next   = stop_reg;
        mem_we      = 1'b0;
        mem_waddr   = wr_ptr_reg[AW-1:0];
        mem_wkey    = mem_rkey;
        mem_wsize   = mem_rsize;
        mem_wfill   = mem_rfill;
        emit_trade  = 1'b0;
        emit_close  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = command;
                    key_next    = order_key;
                    side_next   = order_side;
                    price_next  = order_price;
                    size_next   = order_size;
                    done_next   = order_done;
                    rd_ptr_next = '0;
                    wr_ptr_next = '0;
                    n_next      = count_reg;
                    stop_next   = 1'b0;
                    sts_next    = STS_OK;
                    if (command == CMD_FULFILL && count_reg == '0)
                        sts_next = STS_FULL;
                    else if (command == CMD_FULFILL && ful_bad)
                        sts_next = STS_BAD;
                    else if (command != CMD_INSERT && command != CMD_ERASE
                             && command != CMD_FULFILL)
                        sts_next = STS_BAD;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    if (cmd_reg == CMD_INSERT)
                    begin
                        priority if (scan_hit)
                            sts_next = STS_DUP;
                        else if (ins_bad)
                            sts_next = STS_BAD;
                        else if (count_reg >= CW'(QUEUE_DEPTH))
                            sts_next = STS_FULL;
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[AW-1:0];
                            mem_wkey   = key_reg;
                            mem_wsize  = size_reg;
                            mem_wfill  = done_reg;
                            count_next = count_reg + CW'(1);
                            vol_next   = vol_sum[VOL_W] ? VOL_MAX : vol_sum[VOL_W-1:0];
                        end
                    end
                    else if (scan_hit)
                    begin
                        vol_next    = (VOL_W'(alu_res.avail) > vol_reg) ? '0
                                    : vol_reg - VOL_W'(alu_res.avail);
                        wr_ptr_next = pidx_reg;
                        rd_ptr_next = pidx_reg + CW'(1);
                    end
                    else
                        sts_next = STS_MISSING;
                end
            end
            ST_SHIFT:
            begin
                if (pv_reg)
                begin
                    mem_we      = 1'b1;
                    wr_ptr_next = wr_ptr_reg + CW'(1);
                end
                if (seq_end)
                    count_next = count_reg - CW'(1);
            end
            ST_WALK:
            begin
                if (pv_reg)
                begin
                    if (stop_reg)
                    begin
                        mem_we      = 1'b1;
                        wr_ptr_next = wr_ptr_reg + CW'(1);
                    end
                    else
                    begin
                        done_next  = done_reg + alu_res.fill;
                        vol_next   = (VOL_W'(alu_res.fill) > vol_reg) ? '0
                                   : vol_reg - VOL_W'(alu_res.fill);
                        emit_trade = (alu_res.fill != '0);
                        stop_next  = ((done_reg + alu_res.fill) == size_reg);
                        if (alu_res.full)
                            count_next = count_reg - CW'(1);
                        else
                        begin
                            mem_we      = 1'b1;
                            mem_wfill   = alu_res.filled_new;
                            wr_ptr_next = wr_ptr_reg + CW'(1);
                        end
                    end
                end
            end
            ST_DONE:
                emit_close = 1'b1;
            default:
            begin
                pv_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            side_cfg_reg  <= 1'b0;
            price_cfg_reg <= '0;
            count_reg     <= '0;
            vol_reg       <= '0;
            pv_reg        <= 1'b0;
            rd_ptr_reg    <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            vol_reg    <= vol_next;
            pv_reg     <= pv_next;
            rd_ptr_reg <= rd_ptr_next;
            strobe_reg <= emit_trade || emit_close;
            if (cfg_write && cfg_index == REG_SIDE)
                side_cfg_reg <= cfg_data[0];
            if (cfg_write && cfg_index == REG_PRICE)
                price_cfg_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        side_reg   <= side_next;
        price_reg  <= price_next;
        size_reg   <= size_next;
        done_reg   <= done_next;
        sts_reg    <= sts_next;
        pidx_reg   <= pidx_next;
        wr_ptr_reg <= wr_ptr_next;
        n_reg      <= n_next;
        stop_reg   <= stop_next;

        kind_reg      <= emit_trade ? KIND_TRADE : KIND_CLOSE;
        ost_reg       <= emit_trade ? STS_OK : sts_reg;
        rkey_out_reg  <= emit_trade ? mem_rkey : '0;
        tvol_reg      <= emit_trade ? alu_res.fill : '0;
        rcomp_reg     <= emit_trade && alu_res.full;
        rfill_out_reg <= (emit_close && cmd_reg == CMD_FULFILL && sts_reg == STS_OK)
                       ? done_reg : '0;
        rcompl_reg    <= emit_close && cmd_reg == CMD_FULFILL && sts_reg == STS_OK
                       && done_reg == size_reg;
        ovol_reg      <= vol_next;
        ocnt_reg      <= count_next;
        last_reg      <= emit_close;
    end

    assign busy             = (state_reg != ST_IDLE);
    assign strobe           = strobe_reg;
    assign item_kind        = kind_reg;
    assign status           = ost_reg;
    assign resting_key      = rkey_out_reg;
    assign traded_volume    = tvol_reg;
    assign resting_complete = rcomp_reg;
    assign request_filled   = rfill_out_reg;
    assign request_complete = rcompl_reg;
    assign open_volume      = ovol_reg;
    assign order_count      = 6'(ocnt_reg);
    assign last             = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not start");

    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> $past(state_reg == ST_DONE))
        else $error("closing result outside completion");

endmodule

`default_nettype wire

>>> hw/rtl/plof_store.sv
// ----------------------------------------------------------------------------
// plof_store
// Slot memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module plof_store
    import plof_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [KEY_W-1:0] wkey,
    input  wire logic [KEY_W-1:0] wsize,
    input  wire logic [KEY_W-1:0] wfill,
    input  wire logic [AW-1:0]    raddr,
    output logic      [KEY_W-1:0] rkey,
    output logic      [KEY_W-1:0] rsize,
    output logic      [KEY_W-1:0] rfill
);

    logic [KEY_W-1:0] key_mem  [DEPTH];
    logic [KEY_W-1:0] size_mem [DEPTH];
    logic [KEY_W-1:0] fill_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[waddr]  <= wkey;
            size_mem[waddr] <= wsize;
            fill_mem[waddr] <= wfill;
        end
        rkey  <= key_mem[raddr];
        rsize <= size_mem[raddr];
        rfill <= fill_mem[raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/plof_alu.sv
// ----------------------------------------------------------------------------
// plof_alu
// Per-slot compare and fill unit shared by search, erase and match walk.
// ----------------------------------------------------------------------------
`default_nettype none

module plof_alu
    import plof_pkg::*;
(
    input  wire logic [KEY_W-1:0] rest_key,
    input  wire logic [KEY_W-1:0] rest_size,
    input  wire logic [KEY_W-1:0] rest_fill,
    input  wire logic [KEY_W-1:0] req_key,
    input  wire logic [KEY_W-1:0] req_avail,
    output match_t                res
);

    logic [KEY_W-1:0] avail;
    logic [KEY_W-1:0] fill;

    always_comb
    begin
        avail = (rest_fill <= rest_size) ? (rest_size - rest_fill) : '0;
        fill  = (avail < req_avail) ? avail : req_avail;
        res.key_hit    = (rest_key == req_key);
        res.avail      = avail;
        res.fill       = fill;
        res.filled_new = rest_fill + fill;
        res.full       = ((rest_fill + fill) == rest_size);
    end

endmodule

`default_nettype wire
